### rtl/assert_macros.svh
// assertion macros shared by the ring audio block
// no dependencies; pulled in by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ECRA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ECRA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/ecra_pkg.sv
// shared types and constants for the cellular automaton ring audio block
// no dependencies
package ecra_pkg;

   localparam int NUM_CELLS = 64;
   localparam int IDX_W     = $clog2(NUM_CELLS);
   localparam int LEN_W     = $clog2(NUM_CELLS + 1);
   localparam int RULE_W    = 8;
   localparam int GEN_W     = 16;
   localparam int SAMPLE_W  = 8;
   localparam int CMD_W     = 2;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 4;

   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   localparam logic [1:0] REG_RULE   = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;
   localparam logic [1:0] REG_LIMIT  = 2'd2;

   localparam logic [RULE_W-1:0] RULE_RESET   = 8'd60;
   localparam logic [LEN_W-1:0]  LENGTH_RESET = LEN_W'(NUM_CELLS);
   localparam logic [GEN_W-1:0]  LIMIT_RESET  = 16'd256;
   localparam logic [IDX_W-1:0]  SEED_RESET   = IDX_W'(NUM_CELLS / 2);

   localparam logic [GEN_W-1:0]    GEN_MAX    = {GEN_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_SET = {SAMPLE_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_CLR = '0;

   typedef struct packed {
      logic              step;
      logic              seed;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_index;
      logic              wr_value;
      logic [RULE_W-1:0] rule;
      logic [IDX_W-1:0]  last_index;
      logic [IDX_W-1:0]  seed_index;
   } cell_ctrl_type;

endpackage

### rtl/ecra_if.sv
// valid/ready channel interfaces for the request and response sides
// depends on ecra_pkg
interface ecra_req_if;
   logic                       valid;
   logic                       ready;
   logic [ecra_pkg::CMD_W-1:0] cmd;
   logic [ecra_pkg::IDX_W-1:0] cell_index;
   logic                       cell_value;

   modport source (output valid, cmd, cell_index, cell_value, input ready);
   modport sink (input valid, cmd, cell_index, cell_value, output ready);
endinterface

interface ecra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ecra_pkg::SAMPLE_W-1:0] sample;
   logic                          generation_end;
   logic                          final_sample;

   modport source (output valid, sample, generation_end, final_sample, input ready);
   modport sink (input valid, sample, generation_end, final_sample, output ready);
endinterface

### rtl/ecra_cell.sv
// one ring cell: holds its bit and applies the rule from its neighbours
// depends on ecra_pkg
module ecra_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  ecra_pkg::cell_ctrl_type       ctrl,
   input  logic [ecra_pkg::IDX_W-1:0]    cell_id,
   input  logic                          left_nb,
   input  logic                          right_nb,
   input  logic                          wrap_nb,
   output logic                          bit_q
);
   import ecra_pkg::*;

   logic bit_ff;
   logic bit_in;
   logic in_ring;
   logic right_bit;
   logic [2:0] pattern;

   assign in_ring   = cell_id <= ctrl.last_index;
   assign right_bit = (cell_id == ctrl.last_index) ? wrap_nb : right_nb;
   assign pattern   = {left_nb, bit_ff, right_bit};

   always_comb begin
      bit_in = bit_ff;
      if (ctrl.seed) begin
         bit_in = (cell_id == ctrl.seed_index);
      end else if (ctrl.wr_en && (cell_id == ctrl.wr_index)) begin
         bit_in = ctrl.wr_value;
      end else if (ctrl.step && in_ring) begin
         bit_in = ctrl.rule[pattern];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= (cell_id == SEED_RESET);
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_q = bit_ff;
endmodule

### rtl/ecra_ring.sv
// row of cells wired as a ring of programmable length, with readout select
// depends on ecra_pkg and ecra_cell
module ecra_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  ecra_pkg::cell_ctrl_type       ctrl,
   input  logic [ecra_pkg::IDX_W-1:0]    rd_index,
   output logic                          rd_bit
);
   import ecra_pkg::*;

   logic [NUM_CELLS-1:0] cells;
   logic                 first_left;

   assign first_left = cells[ctrl.last_index];
   assign rd_bit     = cells[rd_index];

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      logic left_nb;
      logic right_nb;

      if (c == 0) begin : g_first
         assign left_nb = first_left;
      end else begin : g_mid
         assign left_nb = cells[c-1];
      end

      if (c == NUM_CELLS - 1) begin : g_end
         assign right_nb = cells[0];
      end else begin : g_inner
         assign right_nb = cells[c+1];
      end

      ecra_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .cell_id  (IDX_W'(c)),
         .left_nb  (left_nb),
         .right_nb (right_nb),
         .wrap_nb  (cells[0]),
         .bit_q    (cells[c])
      );
   end
endmodule

### rtl/elementary_ca_ring_audio.sv
// top level: request/response channels, register port, readout and generation control
// depends on ecra_pkg, ecra_if, ecra_ring and assert_macros.svh
//
// Usage
//   req_ch carries commands: tick (emit one sample), write one cell, restart with
//   a single centre cell. Only a tick that arrives before the generation limit is
//   reached gives a response; writes, restarts, finished ticks and the unused code
//   give none.
//   rsp_ch returns the sample (all ones for a set cell, zero otherwise), a flag on
//   the last cell of each generation and a flag on the final sample of the run.
//   The register port sets the rule, the ring length and the generation limit;
//   write it only while no transaction is in flight.
// Timing
//   one transaction per cycle on req_ch; a response is registered and appears in
//   the cycle after its tick is accepted. The whole ring steps to its next generation
//   in the same edge that accepts the last tick of a generation, every cell of the ring
//   updating in parallel. When rsp_ch stalls, the held response blocks req_ch only
//   while it is not being taken, so a draining receiver sees no gap.
// Reset
//   synchronous; restores register defaults (rule 60, length 64, limit 256), the
//   centre cell alone set, position and generation count zero, no response pending.
`include "assert_macros.svh"

module elementary_ca_ring_audio (
   input  logic                           clock,
   input  logic                           reset,
   ecra_req_if.sink                       req_ch,
   ecra_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ecra_pkg::ADDR_W-1:0]    paddr,
   input  logic [ecra_pkg::DATA_W-1:0]    pwdata,
   output logic [ecra_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import ecra_pkg::*;

   logic [RULE_W-1:0]   rule_ff;
   logic [LEN_W-1:0]    length_ff;
   logic [GEN_W-1:0]    limit_ff;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                gen_end_ff, gen_end_in;
   logic                final_ff, final_in;

   logic [1:0]          reg_sel;
   logic                reg_write;
   logic [LEN_W-1:0]    len_used;
   logic [IDX_W-1:0]    last_index;
   logic [GEN_W-1:0]    limit_used;
   logic                finished;
   logic                accept;
   logic                is_tick;
   logic                is_write;
   logic                is_restart;
   logic                produce;
   logic                last;
   logic                fin;
   logic                rd_bit;
   cell_ctrl_type       ctrl;

   // register port
   assign pready    = 1'b1;
   assign reg_sel   = paddr[3:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      case (reg_sel)
         REG_RULE:   prdata = DATA_W'(rule_ff);
         REG_LENGTH: prdata = DATA_W'(length_ff);
         REG_LIMIT:  prdata = DATA_W'(limit_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= RULE_RESET;
         length_ff <= LENGTH_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (reg_write) begin
         case (reg_sel)
            REG_RULE:   rule_ff   <= pwdata[RULE_W-1:0];
            REG_LENGTH: length_ff <= pwdata[LEN_W-1:0];
            REG_LIMIT:  limit_ff  <= pwdata[GEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamped length and limit
   always_comb begin
      if (length_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (length_ff > LEN_W'(NUM_CELLS)) begin
         len_used = LEN_W'(NUM_CELLS);
      end else begin
         len_used = length_ff;
      end
   end

   assign last_index = IDX_W'(len_used - LEN_W'(1));
   assign limit_used = (limit_ff == '0) ? GEN_W'(1) : limit_ff;
   assign finished   = gen_ff >= limit_used;

   // request handling
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_tick      = accept && (req_ch.cmd == CMD_TICK);
   assign is_write     = accept && (req_ch.cmd == CMD_WRITE);
   assign is_restart   = accept && (req_ch.cmd == CMD_RESTART);
   assign produce      = is_tick && !finished;
   assign last         = pos_ff >= last_index;
   assign fin          = last && ({1'b0, gen_ff} + 17'd1 == {1'b0, limit_used});

   assign ctrl.step       = produce && last;
   assign ctrl.seed       = is_restart;
   assign ctrl.wr_en      = is_write;
   assign ctrl.wr_index   = req_ch.cell_index;
   assign ctrl.wr_value   = req_ch.cell_value;
   assign ctrl.rule       = rule_ff;
   assign ctrl.last_index = last_index;
   assign ctrl.seed_index = len_used[LEN_W-1:1];

   ecra_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .rd_index (pos_ff),
      .rd_bit   (rd_bit)
   );

   always_comb begin
      pos_in = pos_ff;
      gen_in = gen_ff;
      if (is_restart) begin
         pos_in = '0;
         gen_in = '0;
      end else if (produce) begin
         if (last) begin
            pos_in = '0;
            if (gen_ff != GEN_MAX) begin
               gen_in = gen_ff + GEN_W'(1);
            end
         end else begin
            pos_in = pos_ff + IDX_W'(1);
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      sample_in    = sample_ff;
      gen_end_in   = gen_end_ff;
      final_in     = final_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
         sample_in    = rd_bit ? SAMPLE_SET : SAMPLE_CLR;
         gen_end_in   = last;
         final_in     = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      gen_end_ff <= gen_end_in;
      final_ff   <= final_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.sample         = sample_ff;
   assign rsp_ch.generation_end = gen_end_ff;
   assign rsp_ch.final_sample   = final_ff;

   // checks
   `ECRA_ASSERT(a_final_ends_gen, clock, reset, rsp_valid_ff && final_ff |-> gen_end_ff, "final sample without generation end")
   `ECRA_ASSERT(a_wrap_after_last, clock, reset, produce && last |=> pos_ff == '0, "position did not wrap after last cell")
   `ECRA_ASSERT(a_finished_frozen, clock, reset, is_tick && finished |=> gen_ff == $past(gen_ff) && pos_ff == $past(pos_ff), "finished tick changed state")
   `ECRA_ASSERT(a_restart_clears, clock, reset, is_restart |=> pos_ff == '0 && gen_ff == '0, "restart left position or count")
   `ECRA_ASSERT(a_gen_end_counts, clock, reset, produce && last && $past(gen_ff) != GEN_MAX |=> gen_ff != $past(gen_ff), "generation count did not advance")
endmodule
